// ----- rtl/core/wlld_pkg.sv -----
// Shared types, codes and sizes of the weighted least-load dispatcher.
`timescale 1ns / 1ps
`default_nettype none
package wlld_pkg;

	localparam int HOSTS = 16;
	localparam int IDX_W = (HOSTS > 1) ? $clog2(HOSTS) : 1;

	localparam int LOAD_W = 8;
	localparam int WGT_W = 9;
	localparam int CNT_W = 5;
	localparam int SCORE_W = 17;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 9;

	localparam logic [WGT_W-1:0] WGT_ONE = 9'd256;

	localparam logic [1:0] MODE_DISPATCH = 2'd0;
	localparam logic [1:0] MODE_RELEASE = 2'd1;
	localparam logic [1:0] MODE_LOAD = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_CPU_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CPU_WEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_WEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LOAD_STEP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HOST_COUNT = 3'd5;

	typedef struct packed {
		logic [1:0]        mode;
		logic [15:0]       request_id;
		logic [3:0]        host_sel;
		logic [LOAD_W-1:0] cpu_load;
		logic [LOAD_W-1:0] ram_load;
	} in_t;

	typedef struct packed {
		logic               granted;
		logic [3:0]         chosen_host;
		logic [15:0]        echo_id;
		logic [SCORE_W-1:0] best_score;
	} out_t;

	typedef struct packed {
		logic [LOAD_W-1:0] cpu_limit;
		logic [LOAD_W-1:0] ram_limit;
		logic [WGT_W-1:0]  cpu_weight;
		logic [WGT_W-1:0]  ram_weight;
		logic [LOAD_W-1:0] load_step;
	} wcfg_t;

	typedef struct packed {
		logic              grant;
		logic              release_all;
		logic              load;
		logic [LOAD_W-1:0] cpu_load;
		logic [LOAD_W-1:0] ram_load;
	} cmd_t;

	typedef struct packed {
		logic               valid;
		logic               found;
		logic [SCORE_W-1:0] best;
		logic [IDX_W-1:0]   pick;
	} scan_t;

endpackage
`default_nettype wire

// ----- rtl/core/wlld_cell.sv -----
// One host cell: holds the host's levels and connection count and passes the scan token on.
`timescale 1ns / 1ps
`default_nettype none
module wlld_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [wlld_pkg::IDX_W-1:0]  idx,
	input  logic                        in_use,
	input  wlld_pkg::wcfg_t             cfg,
	input  wlld_pkg::cmd_t              cmd,
	input  logic                        grant_hit,
	input  logic                        load_hit,
	input  wlld_pkg::scan_t             scan_in,
	output wlld_pkg::scan_t             scan_out
);

	logic [wlld_pkg::LOAD_W-1:0]  cpu_level_q;
	logic [wlld_pkg::LOAD_W-1:0]  ram_level_q;
	logic [wlld_pkg::LOAD_W-1:0]  links_q;
	logic [wlld_pkg::SCORE_W-1:0] score_q;
	logic                         elig_q;
	wlld_pkg::scan_t              scan_q;

	logic [wlld_pkg::SCORE_W-1:0] cpu_prod;
	logic [wlld_pkg::SCORE_W-1:0] ram_prod;
	logic [wlld_pkg::LOAD_W:0]    cpu_sum;
	logic [wlld_pkg::LOAD_W:0]    ram_sum;
	logic                         take;

	assign cpu_prod = wlld_pkg::SCORE_W'(cpu_level_q) * wlld_pkg::SCORE_W'(cfg.cpu_weight);
	assign ram_prod = wlld_pkg::SCORE_W'(ram_level_q) * wlld_pkg::SCORE_W'(cfg.ram_weight);
	assign cpu_sum = {1'b0, cpu_level_q} + {1'b0, cfg.load_step};
	assign ram_sum = {1'b0, ram_level_q} + {1'b0, cfg.load_step};
	assign take = elig_q && (!scan_in.found || (score_q < scan_in.best));
	assign scan_out = scan_q;

	always_ff @(posedge clk) begin
		score_q <= cpu_prod + ram_prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_level_q <= '0;
			ram_level_q <= '0;
			links_q <= '0;
			elig_q <= 1'b0;
			scan_q <= '0;
		end else begin
			elig_q <= in_use && (cpu_level_q <= cfg.cpu_limit) && (ram_level_q <= cfg.ram_limit);

			scan_q.valid <= scan_in.valid;
			if (take) begin
				scan_q.found <= 1'b1;
				scan_q.best <= score_q;
				scan_q.pick <= idx;
			end else begin
				scan_q.found <= scan_in.found;
				scan_q.best <= scan_in.best;
				scan_q.pick <= scan_in.pick;
			end

			if (cmd.grant && grant_hit) begin
				cpu_level_q <= cpu_sum[wlld_pkg::LOAD_W] ? '1 : cpu_sum[wlld_pkg::LOAD_W-1:0];
				ram_level_q <= ram_sum[wlld_pkg::LOAD_W] ? '1 : ram_sum[wlld_pkg::LOAD_W-1:0];
				links_q <= (links_q == '1) ? links_q : links_q + 1'b1;
			end else if (cmd.release_all && (links_q != '0)) begin
				links_q <= links_q - 1'b1;
				cpu_level_q <= (cpu_level_q > cfg.load_step) ? cpu_level_q - cfg.load_step : '0;
				ram_level_q <= (ram_level_q > cfg.load_step) ? ram_level_q - cfg.load_step : '0;
			end else if (cmd.load && load_hit) begin
				cpu_level_q <= cmd.cpu_load;
				ram_level_q <= cmd.ram_load;
				links_q <= '0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/weighted_least_load_dispatcher.sv -----
// Top level of the weighted least-load dispatcher: control, configuration and the row of host cells.
// A dispatch beat's result is captured once the scan token has passed the last host cell, then registered.
// The scan token walks the host cells one cell per cycle, and no new beat is taken until a dispatch is done.
// Release and load beats go from idle straight to the done state, with no scan, and give their result there.
// A held output keeps a beat in the done state until the earlier result beat is taken.
// Reset clears all host levels and connection counts and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module weighted_least_load_dispatcher (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  wlld_pkg::in_t                       in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output wlld_pkg::out_t                      out_data,
	input  logic                                cfg_we,
	input  logic [wlld_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [wlld_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                    state_q;
	logic                          start_q;
	logic                          out_valid_q;
	wlld_pkg::out_t                out_q;
	wlld_pkg::in_t                 item_q;
	wlld_pkg::scan_t               res_q;

	logic [wlld_pkg::LOAD_W-1:0]   cpu_limit_q;
	logic [wlld_pkg::LOAD_W-1:0]   ram_limit_q;
	logic [wlld_pkg::WGT_W-1:0]    cpu_weight_q;
	logic [wlld_pkg::WGT_W-1:0]    ram_weight_q;
	logic [wlld_pkg::LOAD_W-1:0]   load_step_q;
	logic [wlld_pkg::CNT_W-1:0]    host_count_q;

	logic                          accept;
	logic                          finish;
	logic                          is_dispatch;
	logic                          granted;
	wlld_pkg::wcfg_t               wcfg;
	wlld_pkg::cmd_t                cmd;
	wlld_pkg::scan_t               chain [wlld_pkg::HOSTS+1];
	logic [wlld_pkg::HOSTS-1:0]    in_use;
	logic [wlld_pkg::HOSTS-1:0]    grant_hit;
	logic [wlld_pkg::HOSTS-1:0]    load_hit;

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign finish = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign is_dispatch = (item_q.mode == wlld_pkg::MODE_DISPATCH);
	assign granted = is_dispatch && res_q.found;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign wcfg.cpu_limit = cpu_limit_q;
	assign wcfg.ram_limit = ram_limit_q;
	assign wcfg.cpu_weight = (cpu_weight_q > wlld_pkg::WGT_ONE) ? wlld_pkg::WGT_ONE : cpu_weight_q;
	assign wcfg.ram_weight = (ram_weight_q > wlld_pkg::WGT_ONE) ? wlld_pkg::WGT_ONE : ram_weight_q;
	assign wcfg.load_step = load_step_q;

	assign cmd.grant = finish && granted;
	assign cmd.release_all = finish && (item_q.mode == wlld_pkg::MODE_RELEASE);
	assign cmd.load = finish && (item_q.mode == wlld_pkg::MODE_LOAD);
	assign cmd.cpu_load = item_q.cpu_load;
	assign cmd.ram_load = item_q.ram_load;

	assign chain[0].valid = start_q;
	assign chain[0].found = 1'b0;
	assign chain[0].best = '0;
	assign chain[0].pick = '0;

	for (genvar i = 0; i < wlld_pkg::HOSTS; i++) begin : g_cell
		assign in_use[i] = (32'(i) < 32'(host_count_q));
		assign load_hit[i] = (32'(item_q.host_sel) == 32'(i));
		assign grant_hit[i] = (32'(res_q.pick) == 32'(i));

		wlld_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (wlld_pkg::IDX_W'(i)),
			.in_use    (in_use[i]),
			.cfg       (wcfg),
			.cmd       (cmd),
			.grant_hit (grant_hit[i]),
			.load_hit  (load_hit[i]),
			.scan_in   (chain[i]),
			.scan_out  (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
			out_valid_q <= 1'b0;
			cpu_limit_q <= 8'd80;
			ram_limit_q <= 8'd80;
			cpu_weight_q <= 9'd128;
			ram_weight_q <= 9'd128;
			load_step_q <= 8'd5;
			host_count_q <= 5'd10;
		end else begin
			start_q <= accept && (in_data.mode == wlld_pkg::MODE_DISPATCH);

			if (cfg_we) begin
				unique case (cfg_idx)
					wlld_pkg::CFG_CPU_LIMIT: cpu_limit_q <= cfg_data[wlld_pkg::LOAD_W-1:0];
					wlld_pkg::CFG_RAM_LIMIT: ram_limit_q <= cfg_data[wlld_pkg::LOAD_W-1:0];
					wlld_pkg::CFG_CPU_WEIGHT: cpu_weight_q <= cfg_data[wlld_pkg::WGT_W-1:0];
					wlld_pkg::CFG_RAM_WEIGHT: ram_weight_q <= cfg_data[wlld_pkg::WGT_W-1:0];
					wlld_pkg::CFG_LOAD_STEP: load_step_q <= cfg_data[wlld_pkg::LOAD_W-1:0];
					wlld_pkg::CFG_HOST_COUNT: host_count_q <= cfg_data[wlld_pkg::CNT_W-1:0];
					default: begin
					end
				endcase
			end

			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_data.mode == wlld_pkg::MODE_DISPATCH) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (chain[wlld_pkg::HOSTS].valid) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
			res_q <= '0;
		end
		if ((state_q == ST_SCAN) && chain[wlld_pkg::HOSTS].valid) begin
			res_q <= chain[wlld_pkg::HOSTS];
		end
		if (finish) begin
			out_q.granted <= granted;
			out_q.chosen_host <= granted ? 4'(res_q.pick) : 4'd0;
			out_q.echo_id <= is_dispatch ? item_q.request_id : 16'd0;
			out_q.best_score <= granted ? res_q.best : '0;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/wlld_chk.sv -----
// Port-level checker for the weighted least-load dispatcher and its bind.
`timescale 1ns / 1ps
`default_nettype none
module wlld_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input wlld_pkg::in_t  in_data,
	input logic           out_valid,
	input logic           out_stall,
	input wlld_pkg::out_t out_data
);

	// A held result beat keeps its contents until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// A result that grants nothing carries no host and no score.
	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.granted |-> (out_data.chosen_host == 4'd0) &&
		(out_data.best_score == '0))
		else $error("ungranted result carries a host or score");

	// Only one beat is worked on at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after a beat");

	// A dispatch never produces its result in the cycle after acceptance.
	a_dispatch_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_data.mode == wlld_pkg::MODE_DISPATCH) && !out_valid
		|=> !out_valid)
		else $error("dispatch result appeared too early");

endmodule

bind weighted_least_load_dispatcher wlld_chk u_wlld_chk (.*);
`default_nettype wire
